/* sv/u8u16_pkg.sv */
package u8u16_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;

    localparam logic [CP_W-1:0]   CP_SUPP_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] SURR_HIGH    = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_LOW     = 16'hDC00;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // one entry of the queue between the byte decoder and the unit emitter
    typedef struct packed {
        logic            has_cp;
        logic            last;
        logic [CP_W-1:0] cp;
    } cp_rec_t;

endpackage

/* sv/u8u16_in_if.sv */
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       string_end;

    modport source (output valid, output data_byte, output string_end, input ready);
    modport sink (input valid, input data_byte, input string_end, output ready);
endinterface

/* sv/u8u16_out_if.sv */
interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        end_of_string;

    modport source (output valid, output code_unit, output unit_valid,
                    output end_of_string, input ready);
    modport sink (input valid, input code_unit, input unit_valid,
                  input end_of_string, output ready);
endinterface

/* sv/u8u16_front.sv */
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    u8u16_in_if.sink      in_ch,
    input  logic          q_ready,
    output logic          push,
    output cp_rec_t       push_rec
);

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      pend_reg, pend_next;
    logic            xfer;
    logic [7:0]      b;
    logic [CP_W-1:0] shifted;
    logic [1:0]      pend_dec;

    assign in_ch.ready = q_ready;
    assign xfer        = in_ch.valid && q_ready;
    assign b           = in_ch.data_byte;
    assign shifted     = {acc_reg[CP_W-7:0], b[5:0]};
    assign pend_dec    = pend_reg - 2'd1;

    always_comb
    begin
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        push_rec.has_cp = 1'b0;
        push_rec.cp     = '0;
        push_rec.last   = in_ch.string_end;
        if (pend_reg != 2'd0)
        begin
            acc_next  = shifted;
            pend_next = pend_dec;
            if (pend_dec == 2'd0)
            begin
                push_rec.has_cp = 1'b1;
                push_rec.cp     = shifted;
                acc_next        = '0;
            end
        end
        else if (b[7] == 1'b0)
        begin
            push_rec.has_cp = 1'b1;
            push_rec.cp     = CP_W'(b);
        end
        else if ((b & LEAD2_MASK) == LEAD2_CODE)
        begin
            acc_next  = CP_W'(b[4:0]);
            pend_next = 2'd1;
        end
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
        begin
            acc_next  = CP_W'(b[3:0]);
            pend_next = 2'd2;
        end
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
        begin
            acc_next  = CP_W'(b[2:0]);
            pend_next = 2'd3;
        end
        // string end drops any open sequence
        if (in_ch.string_end)
        begin
            acc_next  = '0;
            pend_next = 2'd0;
        end
    end

    assign push = xfer && (push_rec.has_cp || push_rec.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= 2'd0;
        end
        else if (xfer)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

/* sv/u8u16_queue.sv */
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cp_rec_t push_rec,
    output logic    not_full,
    input  logic    pop,
    output cp_rec_t pop_rec,
    output logic    not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cp_rec_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign not_full  = (cnt_reg != CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_rec   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_rec;
    end

endmodule

/* sv/u8u16_back.sv */
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  cp_rec_t       q_rec,
    output logic          pop,
    u8u16_out_if.source   out_ch
);

    logic              ovalid_reg, ovalid_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic              uvalid_reg, uvalid_next;
    logic              eos_reg, eos_next;
    logic              lowp_reg, lowp_next;
    logic [UNIT_W-1:0] low_reg, low_next;
    logic              low_eos_reg, low_eos_next;
    logic              load_ok;
    logic [CP_W-1:0]   cp_off;

    assign load_ok = !ovalid_reg || out_ch.ready;
    assign cp_off  = q_rec.cp - CP_SUPP_BASE;
    assign pop     = load_ok && !lowp_reg && q_valid;

    always_comb
    begin
        ovalid_next  = ovalid_reg;
        unit_next    = unit_reg;
        uvalid_next  = uvalid_reg;
        eos_next     = eos_reg;
        lowp_next    = lowp_reg;
        low_next     = low_reg;
        low_eos_next = low_eos_reg;
        if (load_ok)
        begin
            ovalid_next = 1'b0;
            if (lowp_reg)
            begin
                // second half of a surrogate pair
                ovalid_next = 1'b1;
                unit_next   = low_reg;
                uvalid_next = 1'b1;
                eos_next    = low_eos_reg;
                lowp_next   = 1'b0;
            end
            else if (q_valid)
            begin
                ovalid_next = 1'b1;
                if (!q_rec.has_cp)
                begin
                    unit_next   = '0;
                    uvalid_next = 1'b0;
                    eos_next    = q_rec.last;
                end
                else if (q_rec.cp < CP_SUPP_BASE)
                begin
                    unit_next   = q_rec.cp[UNIT_W-1:0];
                    uvalid_next = 1'b1;
                    eos_next    = q_rec.last;
                end
                else
                begin
                    unit_next    = SURR_HIGH + UNIT_W'(cp_off[CP_W-1:10]);
                    uvalid_next  = 1'b1;
                    eos_next     = 1'b0;
                    lowp_next    = 1'b1;
                    low_next     = SURR_LOW | UNIT_W'(cp_off[9:0]);
                    low_eos_next = q_rec.last;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            lowp_reg   <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            lowp_reg   <= lowp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg    <= unit_next;
        uvalid_reg  <= uvalid_next;
        eos_reg     <= eos_next;
        low_reg     <= low_next;
        low_eos_reg <= low_eos_next;
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.code_unit     = unit_reg;
    assign out_ch.unit_valid    = uvalid_reg;
    assign out_ch.end_of_string = eos_reg;

endmodule

/* sv/utf8_to_utf16_stream_core.sv */
// A result is presented after the transfer of the byte that completes it (the
// transfer writes the queue, then the output register is loaded from the queue
// once free). Throughput: one byte per cycle while the queue is not full; a code
// point above 0xFFFF sends two units, high then low surrogate, through the output
// register, absorbed by the queue between decoder and emitter.
// Reset (rst_n low, asynchronous) closes any open sequence, empties the queue
// and clears the output valid flag and any pending low surrogate.
module utf8_to_utf16_stream_core
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    u8u16_in_if.sink    in_ch,
    u8u16_out_if.source out_ch
);

    logic    push, not_full, pop, not_empty;
    cp_rec_t push_rec, pop_rec;

    u8u16_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_ready  (not_full),
        .push     (push),
        .push_rec (push_rec)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .not_full  (not_full),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .not_empty (not_empty)
    );

    u8u16_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (not_empty),
        .q_rec   (pop_rec),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule

/* sv/u8u16_checker.sv */
module u8u16_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] code_unit,
    input logic        unit_valid,
    input logic        end_of_string
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(code_unit) && $stable(unit_valid) && $stable(end_of_string))
        else $error("output payload changed while stalled");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unit_valid |-> end_of_string && code_unit == 16'h0000)
        else $error("result without a unit is not a bare end marker");

    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind utf8_to_utf16_stream_core u8u16_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .code_unit     (out_ch.code_unit),
    .unit_valid    (out_ch.unit_valid),
    .end_of_string (out_ch.end_of_string)
);
